FILE: hw/rtl/acfd_pkg.sv
// Package: shared types, codes and reset constants of the ASCII command frame decoder.
`default_nettype none

package acfd_pkg;

  // Store depth default
  localparam int FRAME_DEPTH_DEFAULT = 16;

  // Configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 8;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_START_MARKER   = 3'd0,
    REG_STOP_MARKER    = 3'd1,
    REG_MOVE_SIGN      = 3'd2,
    REG_FLAG_POSITION  = 3'd3,
    REG_ANGLE_POSITION = 3'd4,
    REG_SPEED_POSITION = 3'd5
  } cfg_reg_t;

  // Register reset values
  localparam logic [7:0] START_MARKER_RST   = 8'd60;
  localparam logic [7:0] STOP_MARKER_RST    = 8'd62;
  localparam logic [7:0] MOVE_SIGN_RST      = 8'd49;
  localparam logic [3:0] FLAG_POSITION_RST  = 4'd1;
  localparam logic [3:0] ANGLE_POSITION_RST = 4'd2;
  localparam logic [3:0] SPEED_POSITION_RST = 4'd5;

  // ASCII zero
  localparam logic [7:0] ASCII_ZERO = 8'd48;

  // Position plus digit offset: 4-bit base + up to 2
  localparam int POS_W = 5;

  // Store read slots of one decode, in issue order
  typedef enum logic [2:0] {
    SLOT_FLAG = 3'd0,
    SLOT_ANG0 = 3'd1,
    SLOT_ANG1 = 3'd2,
    SLOT_ANG2 = 3'd3,
    SLOT_SPD0 = 3'd4,
    SLOT_SPD1 = 3'd5,
    SLOT_SPD2 = 3'd6
  } slot_t;

  // Decode sequencer
  typedef enum logic [1:0] {
    SEQ_IDLE = 2'd0,
    SEQ_READ = 2'd1,
    SEQ_LAST = 2'd2,
    SEQ_EMIT = 2'd3
  } seq_state_t;

  // Control from sequencer to digit accumulator
  typedef struct packed {
    logic  clear;  // new decode starts
    logic  act;    // read data valid this cycle
    slot_t slot;   // slot of the read data
    logic  zero;   // entry out of range or never written: reads as zero
  } acc_ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/acfd_ifs.sv
// Interfaces: received-byte channel and decoded-result channel.
`default_nettype none

interface acfd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface acfd_res_if;
  logic        valid;
  logic        ready;
  logic        move_flag;
  logic [15:0] angle_value;
  logic [31:0] speed_value;

  modport source (output valid, output move_flag, output angle_value, output speed_value,
                  input ready);
  modport sink   (input valid, input move_flag, input angle_value, input speed_value,
                  output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/ascii_command_frame_decoder.sv
// Top level: ASCII command frame decoder with frame store RAM and decode sequencer.
//
// Usage: bytes enter on the rx channel (valid/ready, field rx_byte), one transfer
// per byte. A start byte opens a frame at position 0, later bytes fill the next
// positions (the last entry is overwritten once the store is full), and a stop
// byte inside a frame yields one transfer on the res channel: move_flag,
// angle_value and speed_value decoded from the store before the stop byte lands.
// Ordinary bytes are taken one per cycle, back to back. A stop byte holds rx.ready low
// while it is decoded: the seven decode reads go one per cycle
// through the single read port of the frame store, then the SEQ_LAST step absorbs the last
// read and the SEQ_EMIT step loads the result register. The result register parts the two
// channels: bytes keep flowing while a result waits; only the next stop byte
// waits for res.ready in its emit step.
// Reset (rst, synchronous) closes any frame, loads the register defaults and
// marks every store entry unwritten, so it reads as zero; no clearing pass.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect at once and
// are to be made only while the block is idle.
`default_nettype none

module ascii_command_frame_decoder #(
  parameter int FRAME_DEPTH = acfd_pkg::FRAME_DEPTH_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  acfd_rx_if.sink                              rx,
  acfd_res_if.source                           res,
  input  wire logic                            cfg_write,
  input  wire logic [acfd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [acfd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = $clog2(FRAME_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(FRAME_DEPTH - 1);

  // Configuration registers
  logic [7:0] start_marker;
  logic [7:0] stop_marker;
  logic [7:0] move_sign;
  logic [3:0] flag_position;
  logic [3:0] angle_position;
  logic [3:0] speed_position;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker   <= acfd_pkg::START_MARKER_RST;
      stop_marker    <= acfd_pkg::STOP_MARKER_RST;
      move_sign      <= acfd_pkg::MOVE_SIGN_RST;
      flag_position  <= acfd_pkg::FLAG_POSITION_RST;
      angle_position <= acfd_pkg::ANGLE_POSITION_RST;
      speed_position <= acfd_pkg::SPEED_POSITION_RST;
    end else if (cfg_write) begin
      case (acfd_pkg::cfg_reg_t'(cfg_index))
        acfd_pkg::REG_START_MARKER:   start_marker   <= cfg_data;
        acfd_pkg::REG_STOP_MARKER:    stop_marker    <= cfg_data;
        acfd_pkg::REG_MOVE_SIGN:      move_sign      <= cfg_data;
        acfd_pkg::REG_FLAG_POSITION:  flag_position  <= cfg_data[3:0];
        acfd_pkg::REG_ANGLE_POSITION: angle_position <= cfg_data[3:0];
        acfd_pkg::REG_SPEED_POSITION: speed_position <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Control state
  acfd_pkg::seq_state_t state, state_next;
  acfd_pkg::slot_t      slot, slot_next;
  logic                 in_frame, in_frame_next;
  logic [AW-1:0]        wr_index, wr_index_next;
  logic [FRAME_DEPTH-1:0] ent_valid;

  // Held stop byte, written after the decode reads
  logic [7:0]    held_byte, held_byte_next;
  logic [AW-1:0] stop_addr, stop_addr_next;

  // Result register
  logic        out_valid;
  logic        out_flag;
  logic [15:0] out_angle;
  logic [31:0] out_speed;

  // Store access
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [7:0]           ram_wdata;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [7:0]           ram_rdata;
  logic [acfd_pkg::POS_W-1:0] rd_pos;
  logic                 rd_in_range;

  acfd_pkg::acc_ctl_t acc_ctl;
  logic        rd_act;
  acfd_pkg::slot_t rd_slot;
  logic        rd_zero;

  logic        accept;
  logic        is_start;
  logic        is_stop;
  logic        out_free;
  logic        emit;
  logic [AW-1:0] wr_inc;
  logic        acc_flag;
  logic [15:0] acc_angle;
  logic [31:0] acc_speed;

  assign rx.ready = (state == acfd_pkg::SEQ_IDLE);
  assign accept   = rx.valid && rx.ready;
  assign is_start = (rx.rx_byte == start_marker);
  assign is_stop  = in_frame && !is_start && (rx.rx_byte == stop_marker);
  assign wr_inc   = (wr_index == LAST_IDX) ? wr_index : wr_index + AW'(1);
  assign out_free = !out_valid || res.ready;
  assign emit     = (state == acfd_pkg::SEQ_EMIT) && out_free;

  // Read address of the current slot; positions past the store read as zero
  always_comb begin
    case (slot)
      acfd_pkg::SLOT_FLAG: rd_pos = {1'b0, flag_position};
      acfd_pkg::SLOT_ANG0: rd_pos = {1'b0, angle_position};
      acfd_pkg::SLOT_ANG1: rd_pos = {1'b0, angle_position} + 5'd1;
      acfd_pkg::SLOT_ANG2: rd_pos = {1'b0, angle_position} + 5'd2;
      acfd_pkg::SLOT_SPD0: rd_pos = {1'b0, speed_position};
      acfd_pkg::SLOT_SPD1: rd_pos = {1'b0, speed_position} + 5'd1;
      acfd_pkg::SLOT_SPD2: rd_pos = {1'b0, speed_position} + 5'd2;
      default:             rd_pos = {1'b0, flag_position};
    endcase
    rd_in_range = (32'(rd_pos) < 32'(FRAME_DEPTH));
    ram_raddr   = AW'(rd_pos);
    ram_re      = (state == acfd_pkg::SEQ_READ);
  end

  // Sequencer: byte handling in idle, then reads, absorb, emit.
  // Input stays stalled until the stop byte is written, so no read meets a write.
  always_comb begin
    state_next     = state;
    slot_next      = slot;
    in_frame_next  = in_frame;
    wr_index_next  = wr_index;
    held_byte_next = held_byte;
    stop_addr_next = stop_addr;
    ram_we         = 1'b0;
    ram_waddr      = wr_inc;
    ram_wdata      = rx.rx_byte;

    case (state)
      acfd_pkg::SEQ_IDLE: begin
        if (accept) begin
          if (is_start) begin
            in_frame_next = 1'b1;
            wr_index_next = '0;
            ram_we        = 1'b1;
            ram_waddr     = '0;
          end else if (is_stop) begin
            in_frame_next  = 1'b0;
            wr_index_next  = wr_inc;
            held_byte_next = rx.rx_byte;
            stop_addr_next = wr_inc;
            slot_next      = acfd_pkg::SLOT_FLAG;
            state_next     = acfd_pkg::SEQ_READ;
          end else if (in_frame) begin
            wr_index_next = wr_inc;
            ram_we        = 1'b1;
          end
        end
      end
      acfd_pkg::SEQ_READ: begin
        if (slot == acfd_pkg::SLOT_SPD2) begin
          state_next = acfd_pkg::SEQ_LAST;
        end else begin
          slot_next = acfd_pkg::slot_t'(slot + 3'd1);
        end
      end
      acfd_pkg::SEQ_LAST: begin
        state_next = acfd_pkg::SEQ_EMIT;
      end
      acfd_pkg::SEQ_EMIT: begin
        if (out_free) begin
          ram_we     = 1'b1;
          ram_waddr  = stop_addr;
          ram_wdata  = held_byte;
          state_next = acfd_pkg::SEQ_IDLE;
        end
      end
      default: begin
        state_next = acfd_pkg::SEQ_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= acfd_pkg::SEQ_IDLE;
      slot      <= acfd_pkg::SLOT_FLAG;
      in_frame  <= 1'b0;
      wr_index  <= '0;
      ent_valid <= '0;
      rd_act    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      slot     <= slot_next;
      in_frame <= in_frame_next;
      wr_index <= wr_index_next;
      rd_act   <= ram_re;
      if (ram_we) begin
        ent_valid[ram_waddr] <= 1'b1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    held_byte <= held_byte_next;
    stop_addr <= stop_addr_next;
    rd_slot   <= slot;
    rd_zero   <= !rd_in_range || !ent_valid[ram_raddr];
    if (emit) begin
      out_flag  <= acc_flag;
      out_angle <= acc_angle;
      out_speed <= acc_speed;
    end
  end

  assign acc_ctl.clear = accept && is_stop;
  assign acc_ctl.act   = rd_act;
  assign acc_ctl.slot  = rd_slot;
  assign acc_ctl.zero  = rd_zero;

  acfd_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  acfd_digit_acc u_acc (
    .clk         (clk),
    .ctl         (acc_ctl),
    .rdata       (ram_rdata),
    .move_sign   (move_sign),
    .move_flag   (acc_flag),
    .angle_value (acc_angle),
    .speed_value (acc_speed)
  );

  assign res.valid       = out_valid;
  assign res.move_flag   = out_flag;
  assign res.angle_value = out_angle;
  assign res.speed_value = out_speed;

  // A new result only comes from the emit step
  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == acfd_pkg::SEQ_EMIT)
    else $error("result raised outside emit step");

  // During a decode the only store write is the held stop byte
  a_no_write_in_decode: assert property (@(posedge clk) disable iff (rst)
    (ram_we && state != acfd_pkg::SEQ_IDLE) |-> state == acfd_pkg::SEQ_EMIT)
    else $error("store written while decode reads are pending");

  // A stop byte starts the read sequence at the flag slot
  a_stop_starts_reads: assert property (@(posedge clk) disable iff (rst)
    (accept && is_stop) |=> (state == acfd_pkg::SEQ_READ && slot == acfd_pkg::SLOT_FLAG))
    else $error("stop byte did not start decode reads");

  // Write index never leaves the store
  a_index_in_store: assert property (@(posedge clk) disable iff (rst)
    wr_index <= LAST_IDX)
    else $error("write index past last entry");

endmodule

`default_nettype wire

FILE: hw/rtl/acfd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module acfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, read data registered when re is set
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/acfd_digit_acc.sv
// Digit accumulator: folds store read data into move flag, angle and speed.
`default_nettype none

module acfd_digit_acc (
  input  wire logic              clk,
  input  wire acfd_pkg::acc_ctl_t ctl,
  input  wire logic [7:0]        rdata,
  input  wire logic [7:0]        move_sign,
  output logic                   move_flag,
  output logic [15:0]            angle_value,
  output logic [31:0]            speed_value
);

  logic [7:0]  byte_val;
  logic [31:0] digit;
  logic [15:0] angle_next;
  logic [31:0] speed_next;

  // Missing entries read as zero; digit is two's complement (c - 48)
  always_comb begin
    byte_val   = ctl.zero ? 8'd0 : rdata;
    digit      = {24'd0, byte_val} - {24'd0, acfd_pkg::ASCII_ZERO};
    angle_next = (angle_value << 3) + (angle_value << 1) + digit[15:0];
    speed_next = (speed_value << 3) + (speed_value << 1) + digit;
  end

  // Horner steps: acc = acc * 10 + digit, most significant digit first
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      move_flag   <= 1'b0;
      angle_value <= 16'd0;
      speed_value <= 32'd0;
    end else if (ctl.act) begin
      case (ctl.slot)
        acfd_pkg::SLOT_FLAG: move_flag <= (byte_val == move_sign);
        acfd_pkg::SLOT_ANG0,
        acfd_pkg::SLOT_ANG1,
        acfd_pkg::SLOT_ANG2: angle_value <= angle_next;
        acfd_pkg::SLOT_SPD0,
        acfd_pkg::SLOT_SPD1,
        acfd_pkg::SLOT_SPD2: speed_value <= speed_next;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire
